@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the key/value table RTL.
// No dependencies; the including module must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is asserted.
`define KVT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("key/value table assertion failed");
// Clocked check that also holds during reset.
`define KVT_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("key/value table reset assertion failed");
`else
`define KVT_ASSERT(label, prop)
`define KVT_ASSERT_RST(label, prop)
`endif
`endif

@@ hw/rtl/kvt_pkg.sv @@
// Types and codes of the key/value table.
// No dependencies; used by the interfaces and all modules of the block.
package kvt_pkg;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int PAIR_W   = 5;

  localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CONTAINS = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                found;
    logic [STATUS_W-1:0] status;
    logic [PAIR_W-1:0]   pair_count;
    logic                is_empty;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

@@ hw/rtl/kvt_req_if.sv @@
// Request channel of the key/value table: valid, ready and one request item.
// Depends on kvt_pkg.
interface kvt_req_if import kvt_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/kvt_rsp_if.sv @@
// Response channel of the key/value table: valid, ready and one result item.
// Depends on kvt_pkg.
interface kvt_rsp_if import kvt_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/kvt_ctrl.sv @@
// Controller of the key/value table: request/response handshakes and sequencing.
// Depends on kvt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kvt_ctrl import kvt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic rsp_valid_q, rsp_valid_d;

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    cmd_o.capture = req_valid_i && (state_q == ST_IDLE);
    // The result register may be reloaded once the pending item leaves it.
    cmd_o.execute = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_ready_i);
  end

  always_comb begin
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q;
    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.capture) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd_o.execute) begin
          state_d     = ST_IDLE;
          rsp_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  `KVT_ASSERT_RST(a_reset_clears, !rst_ni |-> (state_q == ST_IDLE) && !rsp_valid_q)
  `KVT_ASSERT(a_exec_gives_result, cmd_o.execute |=> rsp_valid_q)
  `KVT_ASSERT(a_capture_then_exec, cmd_o.capture |=> (state_q == ST_EXEC) && !req_ready_o)

endmodule

@@ hw/rtl/kvt_dp.sv @@
// Datapath of the key/value table: pair storage, key compare, update and result register.
// Depends on kvt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kvt_dp import kvt_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  req_t req_i,
  output rsp_t rsp_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [KEY_WIDTH-1:0]   key_q [CAPACITY];
  logic [VALUE_WIDTH-1:0] val_q [CAPACITY];

  logic [OP_W-1:0]        op_q;
  logic [KEY_WIDTH-1:0]   rkey_q;
  logic [VALUE_WIDTH-1:0] rval_q;
  logic [KEY_WIDTH-1:0]   in_key;

  logic [CAPACITY-1:0]    match_q, match_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d, last_cnt;

  logic                   hit, full;
  logic [IDX_W-1:0]       slot, last_idx, tail_idx, wr_idx;
  logic                   wr_en;
  logic [KEY_WIDTH-1:0]   wr_key;
  logic [VALUE_WIDTH-1:0] wr_val;
  logic [STATUS_W-1:0]    status;
  rsp_t                   rsp_q;

  assign in_key = KEY_WIDTH'(req_i.key);

  // First cycle: compare the incoming key against every occupied entry.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_d[i] = (CNT_W'(i) < cnt_q) && (key_q[i] == in_key);
    end
  end

  // Keys are unique, so at most one match bit is set.
  always_comb begin
    slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        slot = IDX_W'(i);
      end
    end
  end

  assign hit      = |match_q;
  assign full     = (cnt_q == CNT_W'(CAPACITY));
  assign last_cnt = cnt_q - CNT_W'(1);
  assign last_idx = last_cnt[IDX_W-1:0];
  assign tail_idx = cnt_q[IDX_W-1:0];

  // Execute step: decide the update and the status.
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = slot;
    wr_key = rkey_q;
    wr_val = rval_q;
    cnt_d  = cnt_q;
    status = STATUS_OK;
    case (op_q)
      OP_INSERT: begin
        if (hit) begin
          wr_en = 1'b1;
        end else if (!full) begin
          wr_en  = 1'b1;
          wr_idx = tail_idx;
          cnt_d  = cnt_q + CNT_W'(1);
        end else begin
          status = STATUS_FULL;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          // The last pair moves into the freed slot.
          wr_en  = 1'b1;
          wr_key = key_q[last_idx];
          wr_val = val_q[last_idx];
          cnt_d  = last_cnt;
        end else begin
          status = STATUS_ABSENT;
        end
      end
      default: begin
        status = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && wr_en) begin
      key_q[wr_idx] <= wr_key;
      val_q[wr_idx] <= wr_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= req_i.op;
      rkey_q <= in_key;
      rval_q <= VALUE_WIDTH'(req_i.value);
    end
    if (cmd_i.execute) begin
      rsp_q.found      <= hit;
      rsp_q.status     <= status;
      rsp_q.pair_count <= PAIR_W'(cnt_d);
      rsp_q.is_empty   <= (cnt_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      match_q <= '0;
    end else begin
      if (cmd_i.capture) begin
        match_q <= match_d;
      end
      if (cmd_i.execute) begin
        cnt_q <= cnt_d;
      end
    end
  end

  assign rsp_o = rsp_q;

  `KVT_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(CAPACITY))
  `KVT_ASSERT(a_match_unique, $onehot0(match_q))
  `KVT_ASSERT(a_cnt_hold, !cmd_i.execute |=> $stable(cnt_q))

endmodule

@@ hw/rtl/key_value_table.sv @@
// Top level of the key/value table: controller plus datapath.
// Depends on kvt_pkg, kvt_req_if, kvt_rsp_if, kvt_ctrl and kvt_dp.
//
// The block holds up to CAPACITY key/value pairs in registers. Each request
// item on req_i carries an operation (insert or update, contains, remove), a
// key and a value. Each request produces exactly one result item on rsp_o
// with the found flag, a status code, the pair count after the operation and
// an empty flag. Inserting a new key into a full table reports a full status
// and changes nothing; removing an absent key reports an absent status.
//
// In the accept cycle the key is compared against all occupied entries in
// parallel and the match vector is registered; in the execute state, once the
// result register is free, the match is encoded, the store and count are
// updated and the result register is loaded. A new request is accepted only
// after the current item has been executed.
//
// The result register separates the two channels: a new request is accepted
// while an earlier result still waits. If the receiver stalls, the execute
// step of the following item waits until the pending result is taken.
// Reset clears the pair count and the handshake state; the stores are not
// cleared, since only entries below the count are ever compared.

module key_value_table import kvt_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  kvt_req_if.sink           req_i,
  kvt_rsp_if.source         rsp_o
);

  // Command bundle from the controller to the datapath.
  cmd_t cmd;

  kvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  kvt_dp #(
    .CAPACITY    (CAPACITY),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i.data),
    .rsp_o  (rsp_o.data)
  );

endmodule
